// ----- rtl/sus_pkg.sv -----
// sus_pkg: shared constants, operation codes, sequencer states and control struct for the
// sorted unique integer set unit. No dependencies.

package sus_pkg;

    localparam int CAPACITY = 512;
    localparam int KEY_BITS = 32;
    localparam int KEY_IN_W = 32;
    localparam int KEY_W    = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
    localparam int POS_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int GROUP    = 32;
    localparam int LOW_W    = $clog2(GROUP);
    localparam int NGRP     = (CAPACITY + GROUP - 1) / GROUP;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_FIND  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_TREE1,
        ST_TREE2,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic clr;
    } t_cell_ctl;

endpackage

// ----- rtl/sus_cell.sv -----
// sus_cell: one slot of the sorted key chain, holding a key and its valid bit.
// Compares against the broadcast key and shifts up on insert. Uses sus_pkg.

module sus_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sus_pkg::t_cell_ctl      i_ctl,
    input  logic [sus_pkg::KEY_W-1:0] i_key,
    input  logic [sus_pkg::KEY_W-1:0] i_prev_key,
    input  logic                    i_prev_lt,
    input  logic                    i_prev_valid,
    output logic [sus_pkg::KEY_W-1:0] o_key,
    output logic                    o_lt,
    output logic                    o_eq,
    output logic                    o_valid
);
    import sus_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic             r_valid;
    logic             r_lt;
    logic             r_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lt    <= 1'b0;
            r_eq    <= 1'b0;
        end else if (i_ctl.clr) begin
            r_valid <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_lt <= r_valid && (r_key < i_key);
            r_eq <= r_valid && (r_key == i_key);
        end else if (i_ctl.ins && !r_lt) begin
            // slots at or above the insert point move up by one
            r_valid <= r_valid | i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !r_lt) begin
            r_key <= i_prev_lt ? i_key : i_prev_key;
        end
    end

    assign o_key   = r_key;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;
    assign o_valid = r_valid;

endmodule

// ----- rtl/sus_hit_tree.sv -----
// sus_hit_tree: two-level registered reduction of the per-slot match flags
// into a hit bit and the matching slot index. Uses sus_pkg.

module sus_hit_tree (
    input  logic                      i_clk,
    input  logic [sus_pkg::CAPACITY-1:0] i_eq,
    output logic                      o_hit,
    output logic [sus_pkg::POS_W-1:0] o_pos
);
    import sus_pkg::*;

    logic [NGRP-1:0]  r_grp_hit;
    logic [LOW_W-1:0] r_grp_idx [NGRP];
    logic [NGRP-1:0]  n_grp_hit;
    logic [LOW_W-1:0] n_grp_idx [NGRP];
    logic             r_hit;
    logic [POS_W-1:0] r_pos;
    logic             n_hit;
    logic [POS_W-1:0] n_pos;

    // keys are unique, so at most one flag is set and an or-encode suffices
    always_comb begin
        n_grp_hit = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_grp_idx[g] = '0;
            for (int j = 0; j < GROUP; j++) begin
                if (g * GROUP + j < CAPACITY) begin
                    if (i_eq[g * GROUP + j]) begin
                        n_grp_hit[g] = 1'b1;
                        n_grp_idx[g] = n_grp_idx[g] | LOW_W'(j);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_hit <= n_grp_hit;
        for (int g = 0; g < NGRP; g++) begin
            r_grp_idx[g] <= n_grp_idx[g];
        end
    end

    always_comb begin
        n_hit = 1'b0;
        n_pos = '0;
        for (int g = 0; g < NGRP; g++) begin
            if (r_grp_hit[g]) begin
                n_hit = 1'b1;
                n_pos = n_pos | POS_W'(g * GROUP + int'(r_grp_idx[g]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= n_hit;
        r_pos <= n_pos;
    end

    assign o_hit = r_hit;
    assign o_pos = r_pos;

endmodule

// ----- rtl/sorted_unique_integer_set_unit.sv -----
// sorted_unique_integer_set_unit: top level with control sequencer, key count
// and result register. Uses sus_pkg, sus_cell and sus_hit_tree.
//
//   channel  | ports                                    | handshake
//   ---------+------------------------------------------+--------------------------
//   command  | i_operation, i_key                       | start high, busy low
//   result   | o_found, o_position, o_count, o_overflow | o_strobe, one cycle
//
// add and find: compare, two reduction stages, then decide and insert; the
// strobe is registered from the decide state and a new beat can be taken
// once busy falls with the strobe. clear and unused codes go straight to decide.
// the reduction stages are the registers of the hit tree over the slot match flags.
// reset empties the set at once (valid bits per slot), no clearing pass.
// the receiver cannot stall; the strobe marks each result for exactly one cycle.

module sorted_unique_integer_set_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic [1:0]                i_operation,
    input  logic [sus_pkg::KEY_IN_W-1:0] i_key,
    output logic                      busy,
    output logic                      o_strobe,
    output logic                      o_found,
    output logic [sus_pkg::POS_W-1:0] o_position,
    output logic [sus_pkg::CNT_W-1:0] o_count,
    output logic                      o_overflow
);
    import sus_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [1:0]       r_op;
    logic [KEY_W-1:0] r_key;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic             r_strobe;
    logic             r_found;
    logic [POS_W-1:0] r_position;
    logic [CNT_W-1:0] r_out_count;
    logic             r_overflow;

    t_cell_ctl        cell_ctl;
    logic             accept;
    logic             lookup;
    logic             hit;
    logic [POS_W-1:0] hit_pos;
    logic             full;
    logic             res_found;
    logic [POS_W-1:0] res_pos;
    logic             res_ovf;

    logic [KEY_W-1:0]    w_key   [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_valid;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);
    assign full   = (r_count == CNT_W'(CAPACITY));
    assign lookup = (r_op == OP_ADD) || (r_op == OP_FIND);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_ADD || i_operation == OP_FIND) begin
                        n_state = ST_CMP;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_CMP:   n_state = ST_TREE1;
            ST_TREE1: n_state = ST_TREE2;
            ST_TREE2: n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        cell_ctl  = '0;
        res_found = 1'b0;
        res_pos   = '0;
        res_ovf   = 1'b0;
        n_count   = r_count;
        unique case (r_state)
            ST_CMP: begin
                cell_ctl.cmp = 1'b1;
            end
            ST_DONE: begin
                if (lookup && hit) begin
                    res_found = 1'b1;
                    res_pos   = hit_pos;
                end else if (r_op == OP_ADD) begin
                    if (full) begin
                        res_ovf = 1'b1;
                    end else begin
                        cell_ctl.ins = 1'b1;
                        n_count      = r_count + CNT_W'(1);
                    end
                end else if (r_op == OP_CLEAR) begin
                    cell_ctl.clr = 1'b1;
                    n_count      = '0;
                end
            end
            default: begin
                cell_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= (r_state == ST_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_operation;
            r_key <= i_key[KEY_W-1:0];
        end
        if (r_state == ST_DONE) begin
            r_found     <= res_found;
            r_position  <= res_pos;
            r_out_count <= n_count;
            r_overflow  <= res_ovf;
        end
    end

    for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
        if (c == 0) begin : g_head
            sus_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (cell_ctl),
                .i_key        (r_key),
                .i_prev_key   (r_key),
                .i_prev_lt    (1'b1),
                .i_prev_valid (1'b1),
                .o_key        (w_key[c]),
                .o_lt         (w_lt[c]),
                .o_eq         (w_eq[c]),
                .o_valid      (w_valid[c])
            );
        end else begin : g_body
            sus_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (cell_ctl),
                .i_key        (r_key),
                .i_prev_key   (w_key[c-1]),
                .i_prev_lt    (w_lt[c-1]),
                .i_prev_valid (w_valid[c-1]),
                .o_key        (w_key[c]),
                .o_lt         (w_lt[c]),
                .o_eq         (w_eq[c]),
                .o_valid      (w_valid[c])
            );
        end
    end

    sus_hit_tree u_hit_tree (
        .i_clk (i_clk),
        .i_eq  (w_eq),
        .o_hit (hit),
        .o_pos (hit_pos)
    );

    assign o_strobe   = r_strobe;
    assign o_found    = r_found;
    assign o_position = r_position;
    assign o_count    = r_out_count;
    assign o_overflow = r_overflow;

endmodule

// ----- bench/sus_set_checker.sv -----
`timescale 1ns / 100ps
// sus_set_checker: watches the command and result channels of the sorted set
// unit, keeps its own copy of the key set and checks every result. Uses sus_pkg.

module sus_set_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [1:0]                   i_operation,
    input  logic [sus_pkg::KEY_IN_W-1:0] i_key,
    input  logic                         i_strobe,
    input  logic                         i_found,
    input  logic [sus_pkg::POS_W-1:0]    i_position,
    input  logic [sus_pkg::CNT_W-1:0]    i_count,
    input  logic                         i_overflow,
    output int                           o_err_count,
    output int                           o_pending,
    output int                           o_checked
);
    import sus_pkg::*;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] count;
        logic             overflow;
    } t_set_result;

    logic [KEY_W-1:0] member_keys [CAPACITY];
    int unsigned      member_total = 0;
    t_set_result      result_fifo [$];
    int               err_total = 0;
    int               checked_total = 0;

    initial begin
        o_err_count = 0;
        o_pending   = 0;
        o_checked   = 0;
    end

    // lowest index whose key is not below k
    function automatic int unsigned first_not_below(input logic [KEY_W-1:0] k);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = member_total;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (member_keys[mid] < k) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic t_set_result apply_command(input logic [1:0] op,
                                                  input logic [KEY_W-1:0] k);
        t_set_result res;
        int unsigned at;
        res = '0;
        case (op)
            OP_ADD, OP_FIND: begin
                at = first_not_below(k);
                if (at < member_total && member_keys[at] == k) begin
                    res.found    = 1'b1;
                    res.position = POS_W'(at);
                end else if (op == OP_ADD) begin
                    if (member_total >= CAPACITY) begin
                        res.overflow = 1'b1;
                    end else begin
                        for (int unsigned j = member_total; j > at; j--)
                            member_keys[j] = member_keys[j-1];
                        member_keys[at] = k;
                        member_total++;
                    end
                end
            end
            OP_CLEAR: member_total = 0;
            default: ;
        endcase
        res.count = CNT_W'(member_total);
        return res;
    endfunction

    function automatic void report_field(input string name, input int unsigned want,
                                         input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            err_total++;
        end
    endfunction

    always @(posedge i_clk) begin : watch_beats
        t_set_result want;
        t_set_result pred;
        if (!i_rst_n) begin
            member_total = 0;
            result_fifo.delete();
        end else begin
            if (i_strobe) begin
                if (result_fifo.size() == 0) begin
                    $display({"%0t: result with nothing outstanding, expected none, ",
                              "actual found=%0d position=%0d count=%0d overflow=%0d"},
                             $time, i_found, i_position, i_count, i_overflow);
                    err_total++;
                end else begin
                    want = result_fifo.pop_front();
                    checked_total++;
                    report_field("found", want.found, i_found);
                    report_field("position", want.position, i_position);
                    report_field("count", want.count, i_count);
                    report_field("overflow", want.overflow, i_overflow);
                end
            end
            // command beat taken at this edge
            if (i_start && !i_busy) begin
                pred        = apply_command(i_operation, i_key[KEY_W-1:0]);
                result_fifo = {result_fifo, pred};
            end
        end
        o_err_count <= err_total;
        o_pending   <= result_fifo.size();
        o_checked   <= checked_total;
    end

endmodule

// ----- bench/sorted_unique_integer_set_unit_tb.sv -----
`timescale 1ns / 100ps
// sorted_unique_integer_set_unit_tb: drives add, find, clear and unused commands
// into the sorted set unit in bursts and reports the verdict of sus_set_checker.

module sorted_unique_integer_set_unit_tb;
    import sus_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RST_CYCLES   = 12;
    localparam int         RANDOM_ITEMS = 400;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         CYCLE_LIMIT  = 300000;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic [1:0]          i_operation = OP_FIND;
    logic [KEY_IN_W-1:0] i_key       = '0;
    logic                busy;
    logic                o_strobe;
    logic                o_found;
    logic [POS_W-1:0]    o_position;
    logic [CNT_W-1:0]    o_count;
    logic                o_overflow;

    int                  err_count;
    int                  pending;
    int                  checked;
    int                  cycle_count = 0;
    int                  burst_left = 0;
    int                  op_tally [4] = '{0, 0, 0, 0};
    logic [KEY_IN_W-1:0] key_pool [$];

    always #2 i_clk = ~i_clk;

    sorted_unique_integer_set_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_key       (i_key),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_found     (o_found),
        .o_position  (o_position),
        .o_count     (o_count),
        .o_overflow  (o_overflow)
    );

    sus_set_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_operation (i_operation),
        .i_key       (i_key),
        .i_strobe    (o_strobe),
        .i_found     (o_found),
        .i_position  (o_position),
        .i_count     (o_count),
        .i_overflow  (o_overflow),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // small range for collisions, full range, and single-bit and single-zero patterns
    function automatic logic [KEY_IN_W-1:0] pick_key();
        int unsigned sel;
        int unsigned b;
        sel = $urandom_range(0, 9);
        b   = $urandom_range(0, KEY_IN_W - 1);
        if (sel < 4) return KEY_IN_W'($urandom_range(0, 63));
        if (sel < 8) return KEY_IN_W'($urandom);
        if (sel == 8) return KEY_IN_W'(1) << b;
        return ~(KEY_IN_W'(1) << b);
    endfunction

    // mostly keys already added, some neighbors of them
    function automatic logic [KEY_IN_W-1:0] pool_key();
        logic [KEY_IN_W-1:0] k;
        int unsigned sel;
        if (key_pool.size() == 0) return pick_key();
        k   = key_pool[$urandom_range(0, key_pool.size() - 1)];
        sel = $urandom_range(0, 9);
        if (sel == 0) return k + 1'b1;
        if (sel == 1) return k - 1'b1;
        return k;
    endfunction

    // holds one command beat until taken, then maybe idles between bursts
    task automatic send_cmd(input logic [1:0] op, input logic [KEY_IN_W-1:0] key);
        int gap;
        start       <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        op_tally[op]++;
        if (op == OP_ADD) key_pool = {key_pool, key};
        else if (op == OP_CLEAR) key_pool.delete();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        int unsigned         sel;
        logic [KEY_IN_W-1:0] k;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // edge keys, present and missing keys, unused code, clears
        send_cmd(OP_FIND, '0);
        send_cmd(OP_ADD, '0);
        send_cmd(OP_ADD, '1);
        send_cmd(OP_ADD, 32'h8000_0000);
        send_cmd(OP_ADD, 32'h7FFF_FFFF);
        send_cmd(OP_ADD, '0);
        send_cmd(OP_ADD, '1);
        send_cmd(OP_FIND, '1);
        send_cmd(OP_FIND, 32'h8000_0000);
        send_cmd(OP_FIND, 32'h5555_5555);
        send_cmd(OP_FIND, 32'hAAAA_AAAA);
        send_cmd(OP_UNUSED, 32'h1234_5678);
        send_cmd(OP_FIND, 32'h1234_5678);
        send_cmd(OP_CLEAR, '1);
        send_cmd(OP_FIND, '0);
        send_cmd(OP_CLEAR, '0);
        send_cmd(OP_ADD, 32'h0000_0001);
        send_cmd(OP_UNUSED, '0);
        send_cmd(OP_CLEAR, '0);

        // fill to capacity with distinct keys, then push past it
        for (int i = 0; i < CAPACITY; i++) begin
            k = KEY_IN_W'($urandom);
            k[POS_W-1:0] = i[POS_W-1:0];
            send_cmd(OP_ADD, k);
        end
        for (int i = 0; i < 6; i++) send_cmd(OP_ADD, pick_key());
        for (int i = 0; i < 6; i++)
            send_cmd(OP_ADD, key_pool[$urandom_range(0, CAPACITY - 1)]);
        for (int i = 0; i < 30; i++) send_cmd(OP_FIND, pool_key());
        send_cmd(OP_UNUSED, pick_key());
        send_cmd(OP_CLEAR, pick_key());

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) send_cmd(OP_ADD, pick_key());
            else if (sel < 45) send_cmd(OP_ADD, pool_key());
            else if (sel < 70) send_cmd(OP_FIND, pool_key());
            else if (sel < 92) send_cmd(OP_FIND, pick_key());
            else if (sel < 96) send_cmd(OP_UNUSED, pick_key());
            else send_cmd(OP_CLEAR, pick_key());
        end
        start <= 1'b0;

        // one edge so the last beat shows up in the outstanding count
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("commands: %0d add, %0d find, %0d clear, %0d unused code",
                 op_tally[OP_ADD], op_tally[OP_FIND], op_tally[OP_CLEAR],
                 op_tally[OP_UNUSED]);
        $display("results checked: %0d, including a full set with overflow %s %0d",
                 checked, "and positions up to", CAPACITY - 1);
        if (err_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
